@@ rtl/core/bmc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package bmc_pkg;

  localparam int unsigned COORD_W = 14;
  localparam int unsigned DIST_W  = 24;
  localparam int unsigned LIM_W   = 17;
  localparam int unsigned AREA_W  = 29;
  localparam int unsigned FRAC_W  = 16;

  localparam int unsigned IDX_W = 2;
  localparam int unsigned CFG_W = 24;

  localparam logic [IDX_W-1:0] REG_DISTANCE = IDX_W'(0);
  localparam logic [IDX_W-1:0] REG_COVER    = IDX_W'(1);
  localparam logic [IDX_W-1:0] REG_OVERLAP  = IDX_W'(2);

  localparam logic [DIST_W-1:0] DIST_RESET = DIST_W'(32768);
  localparam logic [LIM_W-1:0]  LIM_RESET  = LIM_W'(32768);

  localparam int unsigned DM_W   = COORD_W + 1;
  localparam int unsigned SQ_W   = 2 * COORD_W;
  localparam int unsigned DSQ_W  = 2 * DM_W;
  localparam int unsigned TERM_W = DSQ_W + SQ_W;
  localparam int unsigned SUM_W  = TERM_W + 1;
  localparam int unsigned P_W    = DIST_W + SQ_W;
  localparam int unsigned PL_W   = (P_W + 1) / 2;
  localparam int unsigned PH_W   = P_W - PL_W;
  localparam int unsigned LHS_W  = SUM_W + 2 * FRAC_W;
  localparam int unsigned RHS_W  = 2 * P_W;
  localparam int unsigned NEAR_W = (LHS_W > RHS_W) ? LHS_W : RHS_W;
  localparam int unsigned CL_W   = LIM_W + SQ_W;

  typedef struct packed {
    logic [DM_W-1:0]    dx;
    logic [DM_W-1:0]    dy;
    logic [COORD_W-1:0] aw;
    logic [COORD_W-1:0] ah;
    logic [COORD_W-1:0] bw;
    logic [COORD_W-1:0] bh;
    logic [COORD_W-1:0] iw;
    logic [COORD_W-1:0] ih;
  } geo_t;

  typedef struct packed {
    logic [SUM_W-1:0]       sum;
    logic [2*PH_W-1:0]      hh;
    logic [PH_W+PL_W-1:0]   hl;
    logic [2*PL_W-1:0]      ll;
    logic [SQ_W-1:0]        inter;
    logic                   a_ok;
    logic                   b_ok;
    logic                   cov_a;
    logic                   cov_b;
  } prod_t;

  typedef struct packed {
    logic              is_match;
    logic              near;
    logic              cov_a;
    logic              cov_b;
    logic [AREA_W-1:0] area;
    logic              degen;
  } res_t;

endpackage

`default_nettype wire

@@ rtl/core/bmc_geom.sv @@
`timescale 1ns / 1ps
`default_nettype none

module bmc_geom
  import bmc_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic signed [COORD_W-1:0] a_left_i,
  input  logic signed [COORD_W-1:0] a_top_i,
  input  logic signed [COORD_W-1:0] a_right_i,
  input  logic signed [COORD_W-1:0] a_bottom_i,
  input  logic signed [COORD_W-1:0] b_left_i,
  input  logic signed [COORD_W-1:0] b_top_i,
  input  logic signed [COORD_W-1:0] b_right_i,
  input  logic signed [COORD_W-1:0] b_bottom_i,
  output logic                      geo_valid_o,
  input  logic                      geo_ready_i,
  output geo_t                      geo_o
);

  typedef struct packed {
    logic signed [COORD_W+1:0] dx;
    logic signed [COORD_W+1:0] dy;
    logic signed [COORD_W:0]   aw;
    logic signed [COORD_W:0]   ah;
    logic signed [COORD_W-1:0] axl;
    logic signed [COORD_W-1:0] axh;
    logic signed [COORD_W-1:0] ayl;
    logic signed [COORD_W-1:0] ayh;
    logic signed [COORD_W-1:0] bxl;
    logic signed [COORD_W-1:0] bxh;
    logic signed [COORD_W-1:0] byl;
    logic signed [COORD_W-1:0] byh;
  } ord_t;

  ord_t s1_d, s1_q;
  geo_t s2_d, s2_q;
  logic s1_v_q, s2_v_q;
  logic s1_ready, s2_ready;

  logic signed [COORD_W+1:0] ndx, ndy;
  logic signed [COORD_W:0]   naw, nah, bw_s, bh_s, iw_s, ih_s;
  logic signed [COORD_W-1:0] ixl, ixh, iyl, iyh;

  assign s2_ready   = !s2_v_q || geo_ready_i;
  assign s1_ready   = !s1_v_q || s2_ready;
  assign in_ready_o = s1_ready;

  always_comb begin
    s1_d.dx = (COORD_W+2)'(a_left_i) + (COORD_W+2)'(a_right_i)
            - (COORD_W+2)'(b_left_i) - (COORD_W+2)'(b_right_i);
    s1_d.dy = (COORD_W+2)'(a_top_i) + (COORD_W+2)'(a_bottom_i)
            - (COORD_W+2)'(b_top_i) - (COORD_W+2)'(b_bottom_i);
    s1_d.aw = (COORD_W+1)'(a_right_i) - (COORD_W+1)'(a_left_i);
    s1_d.ah = (COORD_W+1)'(a_bottom_i) - (COORD_W+1)'(a_top_i);
    s1_d.axl = (a_left_i > a_right_i) ? a_right_i : a_left_i;
    s1_d.axh = (a_left_i > a_right_i) ? a_left_i : a_right_i;
    s1_d.ayl = (a_top_i > a_bottom_i) ? a_bottom_i : a_top_i;
    s1_d.ayh = (a_top_i > a_bottom_i) ? a_top_i : a_bottom_i;
    s1_d.bxl = (b_left_i > b_right_i) ? b_right_i : b_left_i;
    s1_d.bxh = (b_left_i > b_right_i) ? b_left_i : b_right_i;
    s1_d.byl = (b_top_i > b_bottom_i) ? b_bottom_i : b_top_i;
    s1_d.byh = (b_top_i > b_bottom_i) ? b_top_i : b_bottom_i;
  end

  always_comb begin
    ndx  = -s1_q.dx;
    ndy  = -s1_q.dy;
    naw  = -s1_q.aw;
    nah  = -s1_q.ah;
    bw_s = (COORD_W+1)'(s1_q.bxh) - (COORD_W+1)'(s1_q.bxl);
    bh_s = (COORD_W+1)'(s1_q.byh) - (COORD_W+1)'(s1_q.byl);
    ixl  = (s1_q.axl > s1_q.bxl) ? s1_q.axl : s1_q.bxl;
    ixh  = (s1_q.axh < s1_q.bxh) ? s1_q.axh : s1_q.bxh;
    iyl  = (s1_q.ayl > s1_q.byl) ? s1_q.ayl : s1_q.byl;
    iyh  = (s1_q.ayh < s1_q.byh) ? s1_q.ayh : s1_q.byh;
    iw_s = (COORD_W+1)'(ixh) - (COORD_W+1)'(ixl);
    ih_s = (COORD_W+1)'(iyh) - (COORD_W+1)'(iyl);
    s2_d.dx = s1_q.dx[COORD_W+1] ? ndx[DM_W-1:0] : s1_q.dx[DM_W-1:0];
    s2_d.dy = s1_q.dy[COORD_W+1] ? ndy[DM_W-1:0] : s1_q.dy[DM_W-1:0];
    s2_d.aw = s1_q.aw[COORD_W] ? naw[COORD_W-1:0] : s1_q.aw[COORD_W-1:0];
    s2_d.ah = s1_q.ah[COORD_W] ? nah[COORD_W-1:0] : s1_q.ah[COORD_W-1:0];
    s2_d.bw = bw_s[COORD_W-1:0];
    s2_d.bh = bh_s[COORD_W-1:0];
    s2_d.iw = (ixh > ixl) ? iw_s[COORD_W-1:0] : '0;
    s2_d.ih = (iyh > iyl) ? ih_s[COORD_W-1:0] : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_v_q <= in_valid_i;
      end
      if (s2_ready) begin
        s2_v_q <= s1_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_ready && in_valid_i) begin
      s1_q <= s1_d;
    end
    if (s2_ready && s1_v_q) begin
      s2_q <= s2_d;
    end
  end

  assign geo_valid_o = s2_v_q;
  assign geo_o       = s2_q;

endmodule

`default_nettype wire

@@ rtl/core/bmc_mult.sv @@
`timescale 1ns / 1ps
`default_nettype none

module bmc_mult
  import bmc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              geo_valid_i,
  output logic              geo_ready_o,
  input  geo_t              geo_i,
  input  logic [DIST_W-1:0] distance_limit_i,
  input  logic [LIM_W-1:0]  cover_limit_i,
  input  logic [LIM_W-1:0]  overlap_limit_i,
  output logic              prod_valid_o,
  input  logic              prod_ready_i,
  output prod_t             prod_o
);

  typedef struct packed {
    logic [DSQ_W-1:0] dx2;
    logic [DSQ_W-1:0] dy2;
    logic [SQ_W-1:0]  aw2;
    logic [SQ_W-1:0]  ah2;
    logic [SQ_W-1:0]  am;
    logic [SQ_W-1:0]  bm;
    logic [SQ_W-1:0]  inter;
    logic             a_ok;
    logic             b_ok;
  } sq_t;

  typedef struct packed {
    logic [TERM_W-1:0] t1;
    logic [TERM_W-1:0] t2;
    logic [P_W-1:0]    p;
    logic [CL_W-1:0]   cl;
    logic [CL_W-1:0]   ol;
    logic [SQ_W-1:0]   inter;
    logic              a_ok;
    logic              b_ok;
  } term_t;

  sq_t   s3_d, s3_q;
  term_t s4_d, s4_q;
  prod_t s5_d, s5_q;
  logic  s3_v_q, s4_v_q, s5_v_q;
  logic  s3_ready, s4_ready, s5_ready;
  logic [CL_W-1:0] inter_sh;

  assign s5_ready    = !s5_v_q || prod_ready_i;
  assign s4_ready    = !s4_v_q || s5_ready;
  assign s3_ready    = !s3_v_q || s4_ready;
  assign geo_ready_o = s3_ready;

  always_comb begin
    s3_d.dx2   = DSQ_W'(geo_i.dx) * DSQ_W'(geo_i.dx);
    s3_d.dy2   = DSQ_W'(geo_i.dy) * DSQ_W'(geo_i.dy);
    s3_d.aw2   = SQ_W'(geo_i.aw) * SQ_W'(geo_i.aw);
    s3_d.ah2   = SQ_W'(geo_i.ah) * SQ_W'(geo_i.ah);
    s3_d.am    = SQ_W'(geo_i.aw) * SQ_W'(geo_i.ah);
    s3_d.bm    = SQ_W'(geo_i.bw) * SQ_W'(geo_i.bh);
    s3_d.inter = SQ_W'(geo_i.iw) * SQ_W'(geo_i.ih);
    s3_d.a_ok  = (geo_i.aw != '0) && (geo_i.ah != '0);
    s3_d.b_ok  = (geo_i.bw != '0) && (geo_i.bh != '0);
  end

  always_comb begin
    s4_d.t1    = TERM_W'(s3_q.dx2) * TERM_W'(s3_q.ah2);
    s4_d.t2    = TERM_W'(s3_q.dy2) * TERM_W'(s3_q.aw2);
    s4_d.p     = P_W'(distance_limit_i) * P_W'(s3_q.am);
    s4_d.cl    = CL_W'(cover_limit_i) * CL_W'(s3_q.am);
    s4_d.ol    = CL_W'(overlap_limit_i) * CL_W'(s3_q.bm);
    s4_d.inter = s3_q.inter;
    s4_d.a_ok  = s3_q.a_ok;
    s4_d.b_ok  = s3_q.b_ok;
  end

  always_comb begin
    inter_sh   = CL_W'(s4_q.inter) << FRAC_W;
    s5_d.sum   = SUM_W'(s4_q.t1) + SUM_W'(s4_q.t2);
    s5_d.hh    = (2*PH_W)'(s4_q.p[P_W-1:PL_W]) * (2*PH_W)'(s4_q.p[P_W-1:PL_W]);
    s5_d.hl    = (PH_W+PL_W)'(s4_q.p[P_W-1:PL_W]) * (PH_W+PL_W)'(s4_q.p[PL_W-1:0]);
    s5_d.ll    = (2*PL_W)'(s4_q.p[PL_W-1:0]) * (2*PL_W)'(s4_q.p[PL_W-1:0]);
    s5_d.inter = s4_q.inter;
    s5_d.a_ok  = s4_q.a_ok;
    s5_d.b_ok  = s4_q.b_ok;
    s5_d.cov_a = s4_q.a_ok && (inter_sh >= s4_q.cl);
    s5_d.cov_b = s4_q.b_ok && (inter_sh >= s4_q.ol);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_v_q <= 1'b0;
      s4_v_q <= 1'b0;
      s5_v_q <= 1'b0;
    end else begin
      if (s3_ready) begin
        s3_v_q <= geo_valid_i;
      end
      if (s4_ready) begin
        s4_v_q <= s3_v_q;
      end
      if (s5_ready) begin
        s5_v_q <= s4_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s3_ready && geo_valid_i) begin
      s3_q <= s3_d;
    end
    if (s4_ready && s3_v_q) begin
      s4_q <= s4_d;
    end
    if (s5_ready && s4_v_q) begin
      s5_q <= s5_d;
    end
  end

  assign prod_valid_o = s5_v_q;
  assign prod_o       = s5_q;

endmodule

`default_nettype wire

@@ rtl/core/bmc_cmp.sv @@
`timescale 1ns / 1ps
`default_nettype none

module bmc_cmp
  import bmc_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  prod_valid_i,
  output logic  prod_ready_o,
  input  prod_t prod_i,
  output logic  res_valid_o,
  input  logic  res_ready_i,
  output res_t  res_o
);

  typedef struct packed {
    logic [NEAR_W-1:0] lhs;
    logic [NEAR_W-1:0] rhs;
    logic [SQ_W-1:0]   inter;
    logic              a_ok;
    logic              b_ok;
    logic              cov_a;
    logic              cov_b;
  } sum_t;

  sum_t s6_d, s6_q;
  res_t s7_d, s7_q;
  logic s6_v_q, s7_v_q;
  logic s6_ready, s7_ready;
  logic near;

  assign s7_ready     = !s7_v_q || res_ready_i;
  assign s6_ready     = !s6_v_q || s7_ready;
  assign prod_ready_o = s6_ready;

  always_comb begin
    s6_d.lhs   = NEAR_W'(prod_i.sum) << (2 * FRAC_W);
    s6_d.rhs   = (NEAR_W'(prod_i.hh) << (2 * PL_W))
               + (NEAR_W'(prod_i.hl) << (PL_W + 1))
               + NEAR_W'(prod_i.ll);
    s6_d.inter = prod_i.inter;
    s6_d.a_ok  = prod_i.a_ok;
    s6_d.b_ok  = prod_i.b_ok;
    s6_d.cov_a = prod_i.cov_a;
    s6_d.cov_b = prod_i.cov_b;
  end

  always_comb begin
    near           = s6_q.a_ok && (s6_q.lhs <= s6_q.rhs);
    s7_d.near      = near;
    s7_d.cov_a     = s6_q.cov_a;
    s7_d.cov_b     = s6_q.cov_b;
    s7_d.is_match  = near && s6_q.cov_a && s6_q.cov_b;
    s7_d.area      = AREA_W'(s6_q.inter);
    s7_d.degen     = !s6_q.a_ok || !s6_q.b_ok;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s6_v_q <= 1'b0;
      s7_v_q <= 1'b0;
    end else begin
      if (s6_ready) begin
        s6_v_q <= prod_valid_i;
      end
      if (s7_ready) begin
        s7_v_q <= s6_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s6_ready && prod_valid_i) begin
      s6_q <= s6_d;
    end
    if (s7_ready && s6_v_q) begin
      s7_q <= s7_d;
    end
  end

  assign res_valid_o = s7_v_q;
  assign res_o       = s7_q;

endmodule

`default_nettype wire

@@ rtl/core/box_match_checker.sv @@
// Channel   Direction  Handshake               Payload
// in        request    in_valid_i/in_ready_o   a_*_i, b_*_i corners
// out       result     out_valid_o/out_ready_i is_match_o .. degenerate_o
// cfg       write      cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// One box pair per cycle sustained while the output is not stalled.
// Seven register stages: order, lengths, squares, products, partial squares,
// wide sum, final compare and output register.
// Each stage holds its own valid bit; a stalled output backs up stage by stage.
// Reset clears the valid bits and loads the default limits; cfg is always ready.
`timescale 1ns / 1ps
`default_nettype none

module box_match_checker
  import bmc_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic signed [COORD_W-1:0] a_left_i,
  input  logic signed [COORD_W-1:0] a_top_i,
  input  logic signed [COORD_W-1:0] a_right_i,
  input  logic signed [COORD_W-1:0] a_bottom_i,
  input  logic signed [COORD_W-1:0] b_left_i,
  input  logic signed [COORD_W-1:0] b_top_i,
  input  logic signed [COORD_W-1:0] b_right_i,
  input  logic signed [COORD_W-1:0] b_bottom_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic                      is_match_o,
  output logic                      near_enough_o,
  output logic                      covers_reference_o,
  output logic                      covers_candidate_o,
  output logic [AREA_W-1:0]         shared_area_o,
  output logic                      degenerate_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [IDX_W-1:0]          cfg_index_i,
  input  logic [CFG_W-1:0]          cfg_data_i
);

  logic [DIST_W-1:0] distance_limit_q;
  logic [LIM_W-1:0]  cover_limit_q;
  logic [LIM_W-1:0]  overlap_limit_q;

  logic  geo_valid, geo_ready;
  geo_t  geo;
  logic  prod_valid, prod_ready;
  prod_t prod;
  res_t  res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      distance_limit_q <= DIST_RESET;
      cover_limit_q    <= LIM_RESET;
      overlap_limit_q  <= LIM_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_DISTANCE: distance_limit_q <= cfg_data_i[DIST_W-1:0];
        REG_COVER:    cover_limit_q    <= cfg_data_i[LIM_W-1:0];
        REG_OVERLAP:  overlap_limit_q  <= cfg_data_i[LIM_W-1:0];
        default: begin
        end
      endcase
    end
  end

  bmc_geom u_geom (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .a_left_i    (a_left_i),
    .a_top_i     (a_top_i),
    .a_right_i   (a_right_i),
    .a_bottom_i  (a_bottom_i),
    .b_left_i    (b_left_i),
    .b_top_i     (b_top_i),
    .b_right_i   (b_right_i),
    .b_bottom_i  (b_bottom_i),
    .geo_valid_o (geo_valid),
    .geo_ready_i (geo_ready),
    .geo_o       (geo)
  );

  bmc_mult u_mult (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .geo_valid_i      (geo_valid),
    .geo_ready_o      (geo_ready),
    .geo_i            (geo),
    .distance_limit_i (distance_limit_q),
    .cover_limit_i    (cover_limit_q),
    .overlap_limit_i  (overlap_limit_q),
    .prod_valid_o     (prod_valid),
    .prod_ready_i     (prod_ready),
    .prod_o           (prod)
  );

  bmc_cmp u_cmp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .prod_valid_i (prod_valid),
    .prod_ready_o (prod_ready),
    .prod_i       (prod),
    .res_valid_o  (out_valid_o),
    .res_ready_i  (out_ready_i),
    .res_o        (res)
  );

  assign is_match_o         = res.is_match;
  assign near_enough_o      = res.near;
  assign covers_reference_o = res.cov_a;
  assign covers_candidate_o = res.cov_b;
  assign shared_area_o      = res.area;
  assign degenerate_o       = res.degen;

`ifndef SYNTHESIS
  a_match_and : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (is_match_o ==
                     (near_enough_o && covers_reference_o && covers_candidate_o)))
    else $error("is_match disagrees with the three tests");

  a_match_flat : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_match_o |-> !degenerate_o)
    else $error("match reported on a flat box");

  a_stall_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled while output is free");
`endif

endmodule

`default_nettype wire

@@ verif/tb_box_match_checker.sv @@
`timescale 1ns / 1ps

module tb_box_match_checker;
  import bmc_pkg::*;

  typedef longint unsigned u64_t;

  typedef struct {
    logic signed [COORD_W-1:0] a_left;
    logic signed [COORD_W-1:0] a_top;
    logic signed [COORD_W-1:0] a_right;
    logic signed [COORD_W-1:0] a_bottom;
    logic signed [COORD_W-1:0] b_left;
    logic signed [COORD_W-1:0] b_top;
    logic signed [COORD_W-1:0] b_right;
    logic signed [COORD_W-1:0] b_bottom;
    int                        gap;
  } box_pair_t;

  localparam logic [IDX_W-1:0] REG_SPARE = IDX_W'(3);
  localparam int COORD_MIN    = -8192;
  localparam int COORD_MAX    = 8191;
  localparam int SETTLE_CYCLES = 20;
  localparam int LONG_HOLD    = 150;
  localparam int RUN_LIMIT    = 5_000_000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic             in_valid = 1'b0;
  logic             out_ready = 1'b0;
  logic             cfg_valid = 1'b0;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;
  box_pair_t        cur_pair = '{default: 0};

  logic              in_ready;
  logic              out_valid;
  logic              is_match;
  logic              near_enough;
  logic              covers_reference;
  logic              covers_candidate;
  logic [AREA_W-1:0] shared_area;
  logic              degenerate;
  logic              cfg_ready;

  logic [DIST_W-1:0] dist_lim = DIST_RESET;
  logic [LIM_W-1:0]  cov_lim = LIM_RESET;
  logic [LIM_W-1:0]  ovl_lim = LIM_RESET;

  box_pair_t pair_q[$];
  res_t      verdict_q[$];
  res_t      want;
  int        gap_cnt = 0;
  int        rx_cnt = 0;
  int        rx_wait = 0;
  int        hold_left = 0;
  int        draw;
  logic      rx_fire;
  bit        tx_burst = 1'b0;
  int        err_cnt = 0;

  box_match_checker DUT (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .in_valid_i         (in_valid),
    .in_ready_o         (in_ready),
    .a_left_i           (cur_pair.a_left),
    .a_top_i            (cur_pair.a_top),
    .a_right_i          (cur_pair.a_right),
    .a_bottom_i         (cur_pair.a_bottom),
    .b_left_i           (cur_pair.b_left),
    .b_top_i            (cur_pair.b_top),
    .b_right_i          (cur_pair.b_right),
    .b_bottom_i         (cur_pair.b_bottom),
    .out_valid_o        (out_valid),
    .out_ready_i        (out_ready),
    .is_match_o         (is_match),
    .near_enough_o      (near_enough),
    .covers_reference_o (covers_reference),
    .covers_candidate_o (covers_candidate),
    .shared_area_o      (shared_area),
    .degenerate_o       (degenerate),
    .cfg_valid_i        (cfg_valid),
    .cfg_ready_o        (cfg_ready),
    .cfg_index_i        (cfg_index),
    .cfg_data_i         (cfg_data)
  );

  initial forever #5 clk = ~clk;

  initial begin
    #(RUN_LIMIT);
    $display("DONE: errors detected");
    $finish;
  end

  function automatic u64_t magnitude(longint v);
    return (v < 0) ? u64_t'(-v) : u64_t'(v);
  endfunction

  function automatic u64_t span_overlap(longint lo1, longint hi1, longint lo2, longint hi2);
    longint lo;
    longint hi;
    lo = (lo1 > lo2) ? lo1 : lo2;
    hi = (hi1 < hi2) ? hi1 : hi2;
    return (hi > lo) ? u64_t'(hi - lo) : 0;
  endfunction

  function automatic logic meets_cover(u64_t inter, u64_t w, u64_t h, u64_t lim);
    if (w == 0 || h == 0) return 1'b0;
    return (inter << FRAC_W) >= lim * w * h;
  endfunction

  function automatic res_t predict_verdict(box_pair_t p);
    longint ax1, ay1, ax2, ay2, bx1, by1, bx2, by2, t;
    u64_t aw, ah, bw, bh, iw, ih, dx, dy, dl;
    logic [127:0] lhs;
    logic [127:0] rhs;
    res_t r;
    ax1 = p.a_left;
    ay1 = p.a_top;
    ax2 = p.a_right;
    ay2 = p.a_bottom;
    bx1 = p.b_left;
    by1 = p.b_top;
    bx2 = p.b_right;
    by2 = p.b_bottom;
    dl = dist_lim;
    r = '0;
    dx = magnitude(ax1 + ax2 - bx1 - bx2);
    dy = magnitude(ay1 + ay2 - by1 - by2);
    aw = magnitude(ax2 - ax1);
    ah = magnitude(ay2 - ay1);
    if (aw != 0 && ah != 0) begin
      lhs = {64'd0, dx * dx} * {64'd0, ah * ah} + {64'd0, dy * dy} * {64'd0, aw * aw};
      lhs = lhs << (2 * FRAC_W);
      rhs = {64'd0, dl * dl} * {64'd0, aw * aw * ah * ah};
      r.near = (lhs <= rhs);
    end
    if (ax1 > ax2) begin t = ax1; ax1 = ax2; ax2 = t; end
    if (ay1 > ay2) begin t = ay1; ay1 = ay2; ay2 = t; end
    if (bx1 > bx2) begin t = bx1; bx1 = bx2; bx2 = t; end
    if (by1 > by2) begin t = by1; by1 = by2; by2 = t; end
    bw = u64_t'(bx2 - bx1);
    bh = u64_t'(by2 - by1);
    iw = span_overlap(ax1, ax2, bx1, bx2);
    ih = span_overlap(ay1, ay2, by1, by2);
    r.cov_a = meets_cover(iw * ih, aw, ah, u64_t'(cov_lim));
    r.cov_b = meets_cover(iw * ih, bw, bh, u64_t'(ovl_lim));
    r.area = AREA_W'(iw * ih);
    r.degen = (aw == 0) || (ah == 0) || (bw == 0) || (bh == 0);
    r.is_match = r.near & r.cov_a & r.cov_b;
    return r;
  endfunction

  task automatic flag_mismatch(string what, u64_t got, u64_t exp_v);
    $display("mismatch at result %0d, %s: got %0d, expected %0d", rx_cnt, what, got, exp_v);
    err_cnt++;
  endtask

  // advance the request channel
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_cnt  <= 0;
    end else begin
      if (in_valid && in_ready === 1'b1) begin
        verdict_q = {verdict_q, predict_verdict(cur_pair)};
      end
      if (!in_valid || in_ready === 1'b1) begin
        if (pair_q.size() != 0 && gap_cnt >= pair_q[0].gap) begin
          cur_pair <= pair_q.pop_front();
          in_valid <= 1'b1;
          gap_cnt  <= 0;
        end else begin
          in_valid <= 1'b0;
          if (pair_q.size() != 0) gap_cnt <= gap_cnt + 1;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      rx_wait   <= 0;
      hold_left <= 0;
    end else begin
      rx_fire = (out_valid === 1'b1) && out_ready;
      if (rx_fire) begin
        rx_cnt++;
        if (verdict_q.size() == 0) begin
          flag_mismatch("result with no request pending", u64_t'(shared_area), 0);
        end else begin
          want = verdict_q.pop_front();
          if (is_match !== want.is_match)
            flag_mismatch("is_match", u64_t'(is_match), u64_t'(want.is_match));
          if (near_enough !== want.near)
            flag_mismatch("near_enough", u64_t'(near_enough), u64_t'(want.near));
          if (covers_reference !== want.cov_a)
            flag_mismatch("covers_reference", u64_t'(covers_reference), u64_t'(want.cov_a));
          if (covers_candidate !== want.cov_b)
            flag_mismatch("covers_candidate", u64_t'(covers_candidate), u64_t'(want.cov_b));
          if (shared_area !== want.area)
            flag_mismatch("shared_area", u64_t'(shared_area), u64_t'(want.area));
          if (degenerate !== want.degen)
            flag_mismatch("degenerate", u64_t'(degenerate), u64_t'(want.degen));
        end
      end
      // hold off long enough to back up the whole pipeline
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else if (rx_fire && (rx_cnt == 500 || rx_cnt == 1300)) begin
        hold_left <= LONG_HOLD;
        out_ready <= 1'b0;
      end else if (rx_fire) begin
        draw = ((rx_cnt % 300) < 60) ? 0 : $urandom_range(0, 14);
        if (draw != 0) begin
          out_ready <= 1'b0;
          rx_wait   <= draw - 1;
        end
      end else if (!out_ready) begin
        if (rx_wait == 0) out_ready <= 1'b1;
        else rx_wait <= rx_wait - 1;
      end
    end
  end

  function automatic int clamp_coord(int v);
    if (v < COORD_MIN) return COORD_MIN;
    if (v > COORD_MAX) return COORD_MAX;
    return v;
  endfunction

  function automatic int spread(int j);
    return int'($urandom_range(0, 2 * j)) - j;
  endfunction

  task automatic draw_corners(output int c[8]);
    int kind, w, h, cx, cy, t;
    kind = $urandom_range(0, 99);
    if (kind < 25) begin
      foreach (c[i]) c[i] = int'($urandom_range(0, 16383)) - 8192;
    end else begin
      w = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 12000) : $urandom_range(1, 300);
      h = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 12000) : $urandom_range(1, 300);
      cx = int'($urandom_range(0, 16383)) - 8192;
      cy = int'($urandom_range(0, 16383)) - 8192;
      c[0] = clamp_coord(cx);
      c[1] = clamp_coord(cy);
      c[2] = clamp_coord(cx + w);
      c[3] = clamp_coord(cy + h);
      if (kind < 32) begin
        for (int i = 0; i < 4; i++) c[i + 4] = c[i];
      end else begin
        c[4] = clamp_coord(c[0] + spread(w / 2 + 1));
        c[5] = clamp_coord(c[1] + spread(h / 2 + 1));
        c[6] = clamp_coord(c[2] + spread(w / 2 + 1));
        c[7] = clamp_coord(c[3] + spread(h / 2 + 1));
      end
      if (kind >= 32 && kind < 42) begin
        t = $urandom_range(0, 3);
        c[t + 2 + (t / 2) * 2] = c[t + (t / 2) * 2];
      end else if (kind >= 42 && kind < 48) begin
        c[$urandom_range(0, 7)] = ($urandom_range(0, 1) != 0) ? COORD_MAX : COORD_MIN;
      end
      for (int s = 0; s < 2; s++) begin
        for (int k = 0; k < 2; k++) begin
          if ($urandom_range(0, 1) != 0) begin
            t = c[4 * s + k];
            c[4 * s + k] = c[4 * s + k + 2];
            c[4 * s + k + 2] = t;
          end
        end
      end
    end
  endtask

  task automatic push_pair(input int c[8]);
    box_pair_t p;
    p.a_left   = COORD_W'(c[0]);
    p.a_top    = COORD_W'(c[1]);
    p.a_right  = COORD_W'(c[2]);
    p.a_bottom = COORD_W'(c[3]);
    p.b_left   = COORD_W'(c[4]);
    p.b_top    = COORD_W'(c[5]);
    p.b_right  = COORD_W'(c[6]);
    p.b_bottom = COORD_W'(c[7]);
    p.gap      = tx_burst ? 0 : $urandom_range(0, 14);
    pair_q = {pair_q, p};
  endtask

  task automatic fill_random(int n);
    int c[8];
    for (int k = 0; k < n; k++) begin
      if (k % 40 == 0) tx_burst = ($urandom_range(0, 3) == 0);
      draw_corners(c);
      push_pair(c);
    end
  endtask

  task automatic wait_idle();
    while (pair_q.size() != 0 || in_valid || verdict_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // called at a rising edge; returns at the edge that takes the write, valid still high
  task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    case (idx)
      REG_DISTANCE: dist_lim = val[DIST_W-1:0];
      REG_COVER:    cov_lim = val[LIM_W-1:0];
      REG_OVERLAP:  ovl_lim = val[LIM_W-1:0];
      default: ;
    endcase
  endtask

  task automatic run_phase(logic [CFG_W-1:0] d, logic [CFG_W-1:0] cv, logic [CFG_W-1:0] ov,
                           int n);
    write_reg(REG_DISTANCE, d);
    write_reg(REG_COVER, cv);
    write_reg(REG_SPARE, CFG_W'($urandom));
    write_reg(REG_OVERLAP, ov);
    cfg_valid <= 1'b0;
    fill_random(n);
    wait_idle();
  endtask

  initial begin : stimulus
    int c[8];
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    tx_burst = 1'b0;
    c = '{0, 0, 100, 100, 0, 0, 100, 100};                 push_pair(c);
    c = '{100, 100, 0, 0, 0, 0, 100, 100};                 push_pair(c);
    c = '{0, 0, 100, 100, 100, 100, 0, 0};                 push_pair(c);
    c = '{-8192, -8192, 8191, 8191, -8192, -8192, 8191, 8191}; push_pair(c);
    c = '{8191, 8191, -8192, -8192, -8192, 8191, 8191, -8192}; push_pair(c);
    c = '{-8192, -8192, -8192, -8192, -8192, -8192, -8192, -8192}; push_pair(c);
    c = '{8191, 8191, 8191, 8191, 8191, 8191, 8191, 8191}; push_pair(c);
    c = '{0, 0, 0, 100, 0, 0, 100, 100};                   push_pair(c);
    c = '{0, 0, 100, 0, 0, 0, 100, 100};                   push_pair(c);
    c = '{0, 0, 100, 100, 50, 0, 50, 100};                 push_pair(c);
    c = '{0, 0, 100, 100, 0, 50, 100, 50};                 push_pair(c);
    c = '{0, 0, 100, 100, 200, 200, 300, 300};             push_pair(c);
    c = '{0, 0, 100, 100, 100, 0, 200, 100};               push_pair(c);
    c = '{0, 0, 100, 100, -50, -50, 150, 150};             push_pair(c);
    c = '{0, 0, 100, 100, 25, 25, 75, 75};                 push_pair(c);
    c = '{0, 0, 100, 100, 30, 0, 130, 100};                push_pair(c);
    c = '{0, 0, 100, 100, 25, 0, 125, 100};                push_pair(c);
    c = '{0, 0, 100, 100, 50, 0, 150, 100};                push_pair(c);
    c = '{0, 0, 1, 1, 8191, 8191, -8192, -8192};           push_pair(c);
    c = '{-8192, 8191, 8191, -8192, 0, 0, 1, 1};           push_pair(c);
    c = '{0, 0, 2, 2, 0, 0, 1, 1};                         push_pair(c);
    fill_random(200);
    wait_idle();
    run_phase(CFG_W'(65536), CFG_W'(49152), CFG_W'(49152), 220);
    run_phase(CFG_W'(0), CFG_W'(0), CFG_W'(0), 200);
    run_phase(CFG_W'(16777215), CFG_W'(65536), CFG_W'(65536), 220);
    run_phase(CFG_W'(16777215), CFG_W'(0), CFG_W'(0), 200);
    run_phase(CFG_W'($urandom_range(0, 262143)), CFG_W'($urandom_range(0, 65536)),
              CFG_W'($urandom_range(0, 65536)), 240);
    run_phase({7'h55, 17'd65537}, {7'h2A, 17'd131071}, {7'h7F, 17'd98304}, 200);
    run_phase(CFG_W'(1), CFG_W'(1), CFG_W'(1), 180);
    run_phase(CFG_W'(98304), CFG_W'(16384), CFG_W'(16384), 240);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/bmc_pkg.sv
rtl/core/bmc_geom.sv
rtl/core/bmc_mult.sv
rtl/core/bmc_cmp.sv
rtl/core/box_match_checker.sv
verif/tb_box_match_checker.sv
